// ===== rtl/edd_pkg.sv =====
package edd_pkg;

    // Frame geometry limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = $clog2(MAX_HEIGHT);

    // Error arithmetic, signed; sums and stored errors in 1/16 units
    localparam int ERROR_BITS = 13;   // one stored below-error per channel
    localparam int QERR_BITS  = 9;    // quantization error v - out, -255..255
    localparam int SUM_BITS   = 15;   // pixel*16 + right carry + above error
    localparam int WORD_BITS  = 3 * ERROR_BITS;

    // Reciprocal multiplier: out = (level * mult) >> MULT_SHIFT
    localparam int MULT_BITS  = 24;
    localparam int MULT_SHIFT = 16;
    localparam int PROD_BITS  = 8 + MULT_BITS;

    // Configuration register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LEVEL_BITS   = 2'd2;

    localparam int CFG_DATA_BITS = 13;

    // Control from the compute stage to the channel datapaths
    typedef struct packed {
        logic adv;       // compute stage hands its pixel on this cycle
        logic last_col;  // pixel is the last one of its row
        logic row_nz;    // pixel is not in row 0, so above error applies
    } edd_ctl_t;

    // ceil(255 * 2^16 / (2^n - 1)) for n = 1..8
    function automatic logic [MULT_BITS-1:0] lvl_mult(input logic [3:0] n);
        logic [MULT_BITS-1:0] m;
        begin
            case (n)
                4'd1:    m = 24'd16711680;
                4'd2:    m = 24'd5570560;
                4'd3:    m = 24'd2387383;
                4'd4:    m = 24'd1114112;
                4'd5:    m = 24'd539087;
                4'd6:    m = 24'd265265;
                4'd7:    m = 24'd131589;
                default: m = 24'd65536;
            endcase
            return m;
        end
    endfunction

endpackage

// ===== rtl/edd_channel.sv =====
// One color channel: sum, clamp, quantize, rescale and error spreading.
// Holds the right-neighbor carry and the two pending below errors.
module edd_channel
    import edd_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  edd_ctl_t                     ctl,
    input  logic [7:0]                   pix,
    input  logic signed [ERROR_BITS-1:0] above,
    input  logic [MULT_BITS-1:0]         mult,
    input  logic [2:0]                   lvl_shift,
    output logic [7:0]                   out_val,
    output logic signed [ERROR_BITS-1:0] wr_prev,   // below-left column entry
    output logic signed [ERROR_BITS-1:0] wr_cur     // current column entry
);

    logic signed [QERR_BITS-1:0]  err_reg, err_next;
    logic signed [ERROR_BITS-1:0] part0_reg, part0_next;
    logic signed [QERR_BITS-1:0]  part1_reg, part1_next;

    logic signed [SUM_BITS-1:0]   err_ext;
    logic signed [SUM_BITS-1:0]   carry;
    logic signed [SUM_BITS-1:0]   above_ext;
    logic signed [SUM_BITS-1:0]   sum;
    logic [7:0]                   v;
    logic [7:0]                   level;
    logic [PROD_BITS-1:0]         prod;
    logic [7:0]                   outv;
    logic signed [QERR_BITS-1:0]  e;
    logic signed [ERROR_BITS-1:0] e_ext;
    logic signed [ERROR_BITS-1:0] p1_ext;

    // Incoming error: 7/16 from the left, stored error from above
    always_comb begin
        err_ext   = SUM_BITS'(err_reg);
        carry     = (err_ext <<< 3) - err_ext;
        above_ext = ctl.row_nz ? SUM_BITS'(above) : '0;
        sum       = $signed({{(SUM_BITS-12){1'b0}}, pix, 4'b0000}) + carry + above_ext;
    end

    // Clamp to 0..255
    always_comb begin
        if (sum[SUM_BITS-1]) begin
            v = 8'd0;
        end else if (|sum[SUM_BITS-2:12]) begin
            v = 8'd255;
        end else begin
            v = sum[11:4];
        end
    end

    // Quantize and rescale to 0..255 through a reciprocal multiply
    always_comb begin
        level = v >> lvl_shift;
        prod  = {{MULT_BITS{1'b0}}, level} * {8'b0, mult};
        outv  = prod[MULT_SHIFT+7:MULT_SHIFT];
        e     = $signed({1'b0, v}) - $signed({1'b0, outv});
    end

    // Below errors: 3/16 to the left column, 5/16 to this one
    always_comb begin
        e_ext   = ERROR_BITS'(e);
        p1_ext  = ERROR_BITS'(part1_reg);
        wr_prev = part0_reg + (e_ext <<< 1) + e_ext;
        wr_cur  = p1_ext + (e_ext <<< 2) + e_ext;
        out_val = outv;
    end

    // Carry state, cleared at the end of each row
    always_comb begin
        err_next   = err_reg;
        part0_next = part0_reg;
        part1_next = part1_reg;
        if (ctl.adv) begin
            if (ctl.last_col) begin
                err_next   = '0;
                part0_next = '0;
                part1_next = '0;
            end else begin
                err_next   = e;
                part0_next = wr_cur;
                part1_next = e;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_reg   <= '0;
            part0_reg <= '0;
            part1_reg <= '0;
        end else begin
            err_reg   <= err_next;
            part0_reg <= part0_next;
            part1_reg <= part1_next;
        end
    end

endmodule

// ===== rtl/error_diffusion_dither.sv =====
// Floyd-Steinberg error-diffusion dither for an RGB pixel stream in raster
// order. Each pixel is quantized to level_bits per channel and rescaled to
// 0..255; its error goes 7/16 right, 3/16 below-left, 5/16 below and 1/16
// below-right, never across an image edge, and row 0 takes no error from
// above. The block takes one pixel per clock unless the output stalls; a
// result passes the compute stage and output registers to the m_ side. That
// rate is set by the left-neighbor error loop and by the line store,
// a 1024 x 39 single-port-write RAM with one read per pixel and one write per
// clock; a row's last pixel has a second write, buffered until a free write
// cycle. The store needs no clearing after reset. Configuration changes do
// not reset the frame position; write them only with no pixel in flight.
module error_diffusion_dither
    import edd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration
    input  logic                     cfg_wr_en,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wr_data,
    // pixel input
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_in_red,
    input  logic [7:0]               s_in_green,
    input  logic [7:0]               s_in_blue,
    // dithered output
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [7:0]               m_out_red,
    output logic [7:0]               m_out_green,
    output logic [7:0]               m_out_blue,
    output logic                     m_frame_end
);

    // Configuration registers
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [3:0]  lvl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 11'd640;
            height_reg <= 13'd480;
            lvl_reg    <= 4'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wr_data[10:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_wr_data;
                REG_LEVEL_BITS:   lvl_reg    <= cfg_wr_data[3:0];
                default: ;
            endcase
        end
    end

    // Effective geometry and level count
    logic [COL_BITS-1:0]  wm1;
    logic [ROW_BITS-1:0]  hm1;
    logic [3:0]           lvl_n;
    logic [2:0]           lvl_shift;
    logic [MULT_BITS-1:0] mult;

    always_comb begin
        if (width_reg == '0) begin
            wm1 = '0;
        end else if (width_reg > 11'(MAX_WIDTH)) begin
            wm1 = COL_BITS'(MAX_WIDTH - 1);
        end else begin
            wm1 = COL_BITS'(width_reg - 11'd1);
        end
        if (height_reg == '0) begin
            hm1 = '0;
        end else if (height_reg > 13'(MAX_HEIGHT)) begin
            hm1 = ROW_BITS'(MAX_HEIGHT - 1);
        end else begin
            hm1 = ROW_BITS'(height_reg - 13'd1);
        end
        if (lvl_reg == 4'd0) begin
            lvl_n = 4'd1;
        end else if (lvl_reg > 4'd8) begin
            lvl_n = 4'd8;
        end else begin
            lvl_n = lvl_reg;
        end
        lvl_shift = 3'(4'd8 - lvl_n);
        mult      = lvl_mult(lvl_n);
    end

    // Handshake and stage control
    logic b_valid_reg, b_valid_next;
    logic m_valid_reg;
    logic b_adv;
    logic s_xfer;

    assign b_adv   = b_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !b_valid_reg || b_adv;
    assign s_xfer  = s_valid && s_ready;

    // Frame position, tracked at the input transfer
    logic [COL_BITS-1:0] col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic                a_last_col;
    logic                a_last_row;
    logic [COL_BITS-1:0] a_x;

    always_comb begin
        a_last_col = (col_reg >= wm1);
        a_last_row = (row_reg >= hm1);
        a_x        = a_last_col ? wm1 : col_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        if (s_xfer) begin
            if (a_last_col) begin
                col_next = '0;
                row_next = a_last_row ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Compute stage registers
    logic [7:0]          b_red_reg, b_green_reg, b_blue_reg;
    logic [COL_BITS-1:0] b_x_reg;
    logic                b_last_col_reg, b_last_row_reg, b_row_nz_reg;

    always_comb begin
        b_valid_next = b_valid_reg;
        if (s_xfer) begin
            b_valid_next = 1'b1;
        end else if (b_adv) begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            b_red_reg      <= s_in_red;
            b_green_reg    <= s_in_green;
            b_blue_reg     <= s_in_blue;
            b_x_reg        <= a_x;
            b_last_col_reg <= a_last_col;
            b_last_row_reg <= a_last_row;
            b_row_nz_reg   <= (row_reg != '0);
        end
    end

    // Line store: read at the input transfer, written from the compute stage
    logic [WORD_BITS-1:0] line_mem [MAX_WIDTH];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 fwd_hit_reg;
    logic [WORD_BITS-1:0] fwd_data_reg;

    logic                 we;
    logic [COL_BITS-1:0]  waddr;
    logic [WORD_BITS-1:0] wdata;

    always_ff @(posedge aclk) begin
        if (we) begin
            line_mem[waddr] <= wdata;
        end
        if (s_xfer) begin
            rd_data_reg <= line_mem[a_x];
        end
    end

    // A write landing on the read edge is forwarded to the compute stage
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            fwd_hit_reg  <= we && (waddr == a_x);
            fwd_data_reg <= wdata;
        end
    end

    // Channel datapaths
    edd_ctl_t                     ctl;
    logic [WORD_BITS-1:0]         above_word;
    logic [7:0]                   out_r, out_g, out_b;
    logic signed [ERROR_BITS-1:0] prev_r, prev_g, prev_b;
    logic signed [ERROR_BITS-1:0] cur_r, cur_g, cur_b;

    assign ctl.adv      = b_adv;
    assign ctl.last_col = b_last_col_reg;
    assign ctl.row_nz   = b_row_nz_reg;
    assign above_word   = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

    edd_channel u_red (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .pix       (b_red_reg),
        .above     (above_word[ERROR_BITS-1:0]),
        .mult      (mult),
        .lvl_shift (lvl_shift),
        .out_val   (out_r),
        .wr_prev   (prev_r),
        .wr_cur    (cur_r)
    );

    edd_channel u_green (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .pix       (b_green_reg),
        .above     (above_word[2*ERROR_BITS-1:ERROR_BITS]),
        .mult      (mult),
        .lvl_shift (lvl_shift),
        .out_val   (out_g),
        .wr_prev   (prev_g),
        .wr_cur    (cur_g)
    );

    edd_channel u_blue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .pix       (b_blue_reg),
        .above     (above_word[3*ERROR_BITS-1:2*ERROR_BITS]),
        .mult      (mult),
        .lvl_shift (lvl_shift),
        .out_val   (out_b),
        .wr_prev   (prev_b),
        .wr_cur    (cur_b)
    );

    // Write arbitration: the last column of a wide row has two writes,
    // the second waits in a one-entry buffer for a free cycle
    logic                 b_x_nz;
    logic                 prim_we;
    logic [COL_BITS-1:0]  prim_addr;
    logic [WORD_BITS-1:0] prim_data;
    logic                 pend_set;
    logic                 pend_valid_reg, pend_valid_next;
    logic [COL_BITS-1:0]  pend_addr_reg;
    logic [WORD_BITS-1:0] pend_data_reg;

    always_comb begin
        b_x_nz    = (b_x_reg != '0);
        prim_we   = b_adv && (b_x_nz || b_last_col_reg);
        prim_addr = b_x_nz ? b_x_reg - 1'b1 : b_x_reg;
        prim_data = b_x_nz ? {prev_b, prev_g, prev_r} : {cur_b, cur_g, cur_r};
        pend_set  = b_adv && b_last_col_reg && b_x_nz;

        we    = prim_we || pend_valid_reg;
        waddr = prim_we ? prim_addr : pend_addr_reg;
        wdata = prim_we ? prim_data : pend_data_reg;

        pend_valid_next = pend_valid_reg;
        if (pend_set) begin
            pend_valid_next = 1'b1;
        end else if (!prim_we) begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_set) begin
            pend_addr_reg <= b_x_reg;
            pend_data_reg <= {cur_b, cur_g, cur_r};
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_adv) begin
            m_out_red   <= out_r;
            m_out_green <= out_g;
            m_out_blue  <= out_b;
            m_frame_end <= b_last_col_reg && b_last_row_reg;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTH
    // A second write never finds the buffer still occupied
    a_pend_free: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_set |-> !pend_valid_reg)
        else $error("line store write buffer overrun");

    // The buffered write drains on the next cycle
    a_pend_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |=> !pend_valid_reg || $past(pend_set))
        else $error("line store write buffer did not drain");

    // A stalled compute stage keeps its pixel
    a_b_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && !b_adv |=> b_valid_reg && $stable(b_x_reg)
            && $stable(b_red_reg) && $stable(b_last_col_reg))
        else $error("compute stage lost a stalled pixel");

    // Every pixel leaving the compute stage is offered on the output
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        b_adv |=> m_valid_reg)
        else $error("output register missed a transfer");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import edd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int          RANDOM_ITEMS = 1150;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } dither_px_t;

    typedef enum int {PIX_UNIFORM, PIX_EXTREME, PIX_SMOOTH} pix_style_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [1:0]               cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_wr_data;
    logic                     s_valid;
    logic                     s_ready;
    logic [7:0]               s_in_red;
    logic [7:0]               s_in_green;
    logic [7:0]               s_in_blue;
    logic                     m_valid;
    logic                     m_ready;
    logic [7:0]               m_out_red;
    logic [7:0]               m_out_green;
    logic [7:0]               m_out_blue;
    logic                     m_frame_end;

    error_diffusion_dither dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_red    (s_in_red),
        .s_in_green  (s_in_green),
        .s_in_blue   (s_in_blue),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_red   (m_out_red),
        .m_out_green (m_out_green),
        .m_out_blue  (m_out_blue),
        .m_frame_end (m_frame_end)
    );

    // Stimulus and expectations
    rgb_t       pixel_queue[$];
    dither_px_t dithered_expected[$];
    int         mismatches = 0;
    int unsigned cycle_count = 0;

    // Handshake pacing
    int send_gap     = 0;
    int send_burst   = 0;
    int stall_left   = 0;
    int recv_burst   = 0;
    rgb_t       next_px;
    dither_px_t want;

    // Predictor copy of configuration and diffusion state
    logic [10:0] cfg_width  = 11'd640;
    logic [12:0] cfg_height = 13'd480;
    logic [3:0]  cfg_levels = 4'd1;
    int          line_err [MAX_WIDTH][3];
    bit          line_written [MAX_WIDTH];
    int          carry_err [3];
    int          pend_below [2][3];
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int unsigned eff_width(input logic [10:0] w);
        if (w == 0)
            return 1;
        if (w > MAX_WIDTH)
            return MAX_WIDTH;
        return 32'(w);
    endfunction

    // A row past row 0 reads the line store; never let it read a column
    // that has not been written since reset.
    function automatic bit width_safe(input logic [10:0] w);
        int unsigned ew;
        int unsigned i;
        ew = eff_width(w);
        if (row_pos == 0)
            return 1'b1;
        for (i = 0; i < ew; i++)
            if (!line_written[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Dither one pixel and advance the frame position
    function automatic dither_px_t dither_pixel(input logic [7:0] r, g, b);
        int unsigned w, h, n, x, lvl;
        bit          at_last_col, at_last_row;
        int          sum, v, q, e, c;
        logic [7:0]  chan_in [3];
        dither_px_t  res;
        chan_in[0] = r;
        chan_in[1] = g;
        chan_in[2] = b;
        w = eff_width(cfg_width);
        h = (cfg_height == 0) ? 1 : (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT
                                                              : 32'(cfg_height);
        n = (cfg_levels == 0) ? 1 : (cfg_levels > 8) ? 8 : 32'(cfg_levels);
        at_last_col = (col_pos >= w - 1);
        at_last_row = (row_pos >= h - 1);
        x = at_last_col ? w - 1 : col_pos;

        for (c = 0; c < 3; c++) begin
            sum = 16 * int'(chan_in[c]) + carry_err[c];
            if (row_pos != 0)
                sum += line_err[x][c];
            if (sum < 0)
                v = 0;
            else begin
                v = sum / 16;
                if (v > 255)
                    v = 255;
            end
            lvl = v >> (8 - n);
            q = (255 * lvl) / ((1 << n) - 1);
            e = v - q;
            case (c)
                0: res.red = q[7:0];
                1: res.green = q[7:0];
                default: res.blue = q[7:0];
            endcase

            // 3/16 below-left is final once this pixel is known
            if (x > 0) begin
                line_err[x-1][c] = pend_below[0][c] + 3 * e;
                line_written[x-1] = 1'b1;
            end
            pend_below[0][c] = pend_below[1][c] + 5 * e;
            pend_below[1][c] = e;
            if (at_last_col) begin
                line_err[x][c] = pend_below[0][c];
                line_written[x] = 1'b1;
                carry_err[c] = 0;
                pend_below[0][c] = 0;
                pend_below[1][c] = 0;
            end else begin
                carry_err[c] = 7 * e;
            end
        end

        res.frame_end = 1'b0;
        if (at_last_col) begin
            col_pos = 0;
            if (at_last_row) begin
                row_pos = 0;
                res.frame_end = 1'b1;
            end else begin
                row_pos = (row_pos + 1) & 32'hFFF;
            end
        end else begin
            col_pos = (col_pos + 1) & (MAX_WIDTH - 1);
        end
        return res;
    endfunction

    // Mostly short gaps, a few long ones, and occasional bursts with none
    function automatic int gap_len(inout int burst_left);
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_left = $urandom_range(20, 100);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic logic [7:0] pick_chan(input pix_style_t style, input int base);
        int v;
        case (style)
            PIX_UNIFORM: v = $urandom_range(0, 255);
            PIX_EXTREME: v = $urandom_range(0, 1) ? $urandom_range(240, 255)
                                                  : $urandom_range(0, 15);
            default: begin
                v = base + int'($urandom_range(0, 16)) - 8;
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
            end
        endcase
        return v[7:0];
    endfunction

    // Pixel driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                dithered_expected.push_back(dither_pixel(s_in_red, s_in_green, s_in_blue));
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pixel_queue.size() != 0) begin
                    next_px = pixel_queue.pop_front();
                    s_valid    <= 1'b1;
                    s_in_red   <= next_px.red;
                    s_in_green <= next_px.green;
                    s_in_blue  <= next_px.blue;
                    send_gap = gap_len(send_burst);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (dithered_expected.size() == 0) begin
                    $error("output transfer with no pixel expected");
                    mismatches++;
                end else begin
                    want = dithered_expected.pop_front();
                    if (m_out_red !== want.red) begin
                        $error("out_red: expected %0d, actual %0d", want.red, m_out_red);
                        mismatches++;
                    end
                    if (m_out_green !== want.green) begin
                        $error("out_green: expected %0d, actual %0d", want.green, m_out_green);
                        mismatches++;
                    end
                    if (m_out_blue !== want.blue) begin
                        $error("out_blue: expected %0d, actual %0d", want.blue, m_out_blue);
                        mismatches++;
                    end
                    if (m_frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0d, actual %0d",
                               want.frame_end, m_frame_end);
                        mismatches++;
                    end
                end
            end
            if (stall_left == 0 && $urandom_range(0, 99) < 25)
                stall_left = gap_len(recv_burst);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_BITS-1:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  cfg_width = val[10:0];
            REG_IMAGE_HEIGHT: cfg_height = val[12:0];
            REG_LEVEL_BITS:   cfg_levels = val[3:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // Called only with nothing in flight
    task automatic apply_setting(input logic [10:0] w, input logic [12:0] h,
                                 input logic [3:0] n);
        if (!width_safe(w))
            w = cfg_width;
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(w));
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_LEVEL_BITS, CFG_DATA_BITS'(n));
    endtask

    task automatic wait_drained(input int settle);
        do
            @(negedge aclk);
        while (pixel_queue.size() != 0 || s_valid || dithered_expected.size() != 0);
        repeat (settle) @(negedge aclk);
    endtask

    task automatic push_px(input logic [7:0] r, g, b);
        pixel_queue.push_back({r, g, b});
    endtask

    initial begin
        int          sent;
        int          count;
        int          r;
        int          base;
        int unsigned ew, eh;
        logic [10:0] w;
        logic [12:0] h;
        pix_style_t  style;

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_IMAGE_WIDTH;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_in_red    = '0;
        s_in_green  = '0;
        s_in_blue   = '0;
        m_ready     = 1'b0;
        foreach (line_err[i, c]) line_err[i][c] = 0;
        foreach (line_written[i]) line_written[i] = 1'b0;
        foreach (carry_err[c]) carry_err[c] = 0;
        foreach (pend_below[i, c]) pend_below[i][c] = 0;

        // Start of row 0 under the reset geometry
        push_px(8'd0, 8'd0, 8'd0);
        push_px(8'd255, 8'd255, 8'd255);
        push_px(8'd128, 8'd127, 8'd1);
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        wait_drained(4);

        // Shrink the width so the current column is the last, then finish a 4x3 frame
        apply_setting(11'd4, 13'd3, 4'd1);
        push_px(8'd170, 8'd85, 8'd255);
        push_px(8'd85, 8'd170, 8'd0);
        push_px(8'd255, 8'd0, 8'd127);
        push_px(8'd0, 8'd255, 8'd128);
        push_px(8'd1, 8'd254, 8'd64);
        push_px(8'd100, 8'd100, 8'd100);
        push_px(8'd255, 8'd255, 8'd255);
        push_px(8'd0, 8'd0, 8'd0);
        push_px(8'd200, 8'd50, 8'd150);
        wait_drained(4);

        // Zero width and height act as 1: every pixel ends a frame; full depth
        apply_setting(11'd0, 13'd0, 4'd8);
        push_px(8'd0, 8'd128, 8'd255);
        push_px(8'd255, 8'd1, 8'd127);
        push_px(8'd77, 8'd200, 8'd3);
        wait_drained(4);

        // Oversized settings clamp to the maxima
        apply_setting(11'd2047, 13'd8191, 4'd15);
        push_px(8'd255, 8'd0, 8'd170);
        push_px(8'd0, 8'd255, 8'd85);
        push_px(8'd128, 8'd128, 8'd128);
        push_px(8'd129, 8'd127, 8'd126);
        wait_drained(4);

        // Shrink mid-row and mid-frame; zero level bits act as 1
        apply_setting(11'd2, 13'd2, 4'd0);
        push_px(8'd60, 8'd190, 8'd128);
        push_px(8'd128, 8'd128, 8'd128);
        push_px(8'd127, 8'd129, 8'd255);
        wait_drained(4);

        // Random frames with random geometry, depth and content
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                w = 11'($urandom_range(1, 8));
            else if (r < 85)
                w = 11'($urandom_range(9, 40));
            else if (r < 90)
                w = 11'd0;
            else if (r < 95)
                w = $urandom_range(0, 1) ? 11'd1024 : 11'd2047;
            else
                w = 11'($urandom_range(41, 1023));

            r = $urandom_range(0, 99);
            if (r < 75)
                h = 13'($urandom_range(1, 5));
            else if (r < 83)
                h = 13'd0;
            else if (r < 90)
                h = 13'($urandom_range(6, 20));
            else if (r < 95)
                h = 13'd8191;
            else
                h = 13'd4096;

            apply_setting(w, h, 4'($urandom_range(0, 15)));

            ew = eff_width(cfg_width);
            eh = (cfg_height == 0) ? 1 : 32'(cfg_height);
            if (ew * eh <= 120) begin
                count = ew * eh * $urandom_range(1, 2);
                if ($urandom_range(0, 99) < 30)
                    count += $urandom_range(1, ew * eh);
            end else begin
                count = $urandom_range(5, 60);
            end

            style = pix_style_t'($urandom_range(0, 2));
            base  = $urandom_range(0, 255);
            repeat (count) begin
                if (style == PIX_SMOOTH && $urandom_range(0, 7) == 0)
                    base = $urandom_range(0, 255);
                push_px(pick_chan(style, base), pick_chan(style, base),
                        pick_chan(style, base));
            end
            sent += count;
            wait_drained($urandom_range(4, 12));
        end

        wait_drained(10);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
